FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/fk7_pkg.sv
// ----------------------------------------------------------------------------
// fk7_pkg
// Types and constants of the seven-joint forward kinematics pipeline.
// ----------------------------------------------------------------------------
package fk7_pkg;

   localparam int JointCount = 7;
   localparam int CordicW    = 28;
   localparam int AccW       = 34;
   localparam int AtanEntries = 20;

   localparam logic signed [16:0] PiQ12     = 17'sd12868;
   localparam logic signed [16:0] TwoPiQ12  = 17'sd25736;
   localparam logic signed [16:0] HalfPiQ12 = 17'sd6434;
   localparam logic signed [CordicW-1:0] GainQ24 = 28'sd10188012;
   localparam logic signed [15:0] UnitQ12   = 16'sd4096;
   localparam logic signed [15:0] ShoulderY = 16'sd770;

   // register indexes of the csr port
   typedef enum logic [7:0] {
      CsrArmSide    = 8'd0,
      CsrOriginRow0 = 8'd1,
      CsrOriginRow1 = 8'd2,
      CsrOriginRow2 = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] angle_0;
      logic signed [15:0] angle_1;
      logic signed [15:0] angle_2;
      logic signed [15:0] angle_3;
      logic signed [15:0] angle_4;
      logic signed [15:0] angle_5;
      logic signed [15:0] angle_6;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] rot_00;
      logic signed [15:0] rot_01;
      logic signed [15:0] rot_02;
      logic signed [15:0] rot_10;
      logic signed [15:0] rot_11;
      logic signed [15:0] rot_12;
      logic signed [15:0] rot_20;
      logic signed [15:0] rot_21;
      logic signed [15:0] rot_22;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
   } rsp_word_type;

   // rounded arctangent table, q.24
   function automatic logic signed [CordicW-1:0] atan_q24(input int idx);
      logic signed [CordicW-1:0] res;
      case (idx)
         0:  res = 28'sd13176795;
         1:  res = 28'sd7778716;
         2:  res = 28'sd4110061;
         3:  res = 28'sd2086331;
         4:  res = 28'sd1047214;
         5:  res = 28'sd524117;
         6:  res = 28'sd262123;
         7:  res = 28'sd131069;
         8:  res = 28'sd65536;
         9:  res = 28'sd32768;
         10: res = 28'sd16384;
         11: res = 28'sd8192;
         12: res = 28'sd4096;
         13: res = 28'sd2048;
         14: res = 28'sd1024;
         15: res = 28'sd512;
         16: res = 28'sd256;
         17: res = 28'sd128;
         18: res = 28'sd64;
         default: res = 28'sd32;
      endcase
      return res;
   endfunction

   // joint rotation axis: 0 x, 1 y, 2 z
   function automatic int joint_axis(input int j);
      int res;
      case (j)
         0:       res = 2;
         1, 3, 5: res = 1;
         default: res = 0;
      endcase
      return res;
   endfunction

   // link translation x component (y only on the shoulder, z always zero)
   function automatic logic signed [15:0] link_x(input int j);
      logic signed [15:0] res;
      case (j)
         1:       res = 16'sd410;
         3:       res = 16'sd1638;
         5:       res = 16'sd1315;
         6:       res = 16'sd737;
         default: res = 16'sd0;
      endcase
      return res;
   endfunction

   // q.24 to q4.12 with round half up and clamp to the unit range
   function automatic logic signed [15:0] round_unit(input logic signed [CordicW-1:0] v);
      logic signed [CordicW-1:0] r;
      logic signed [15:0] res;
      r = (v + 28'sd2048) >>> 12;
      if (r > 28'sd4096) res = 16'sd4096;
      else if (r < -28'sd4096) res = -16'sd4096;
      else res = r[15:0];
      return res;
   endfunction

   // q.24 sum to q4.12 with round half up and saturation
   function automatic logic signed [15:0] round_sat(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] r;
      logic signed [15:0] res;
      r = (v + 34'sd2048) >>> 12;
      if (r > 34'sd32767) res = 16'sd32767;
      else if (r < -34'sd32768) res = -16'sd32768;
      else res = r[15:0];
      return res;
   endfunction

endpackage

FILE: rtl/core/seven_joint_arm_forward_kinematics.sv
// ----------------------------------------------------------------------------
// seven_joint_arm_forward_kinematics
// Pipelined forward kinematics of a seven-joint arm, q4.12 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word of seven joint angles, taken when req_valid is high
//   and req_stall is low. rsp channel: one pose word per request word, in
//   order, with the same valid/stall rule.
//   csr port: write arm side and the three base transform rows while idle.
// Stages: CORDIC_STEPS + 9 register stages (one angle reduction stage, one
//   stage per cordic iteration, one rounding stage, one matrix product stage
//   per joint).
// Throughput: one word per cycle while rsp_stall does not hold a valid output
//   word; each stage holds one register slice and the seven cordic units run side by side.
// Reset: clears every stage valid bit, sets the base transform to identity
//   and selects the left arm.
// Stall: while rsp_stall holds a valid output word the whole pipeline
//   freezes and req_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module seven_joint_arm_forward_kinematics #(
   parameter int CORDIC_STEPS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fk7_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fk7_pkg::rsp_word_type  rsp_word,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_index,
   input  logic [63:0]            csr_wr_data
);

   localparam int Nj  = fk7_pkg::JointCount;
   localparam int Cw  = fk7_pkg::CordicW;
   localparam int Lat = CORDIC_STEPS + 2 + Nj;
   localparam int Rnd = CORDIC_STEPS + 1;

   // csr registers
   logic        side_ff;
   logic [63:0] origin_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= 1'b0;
         origin_ff[0] <= 64'd4096;
         origin_ff[1] <= 64'd268435456;
         origin_ff[2] <= 64'd17592186044416;
      end else if (csr_wr_en) begin
         case (fk7_pkg::csr_index_type'(csr_index))
            fk7_pkg::CsrArmSide:    side_ff      <= csr_wr_data[0];
            fk7_pkg::CsrOriginRow0: origin_ff[0] <= csr_wr_data;
            fk7_pkg::CsrOriginRow1: origin_ff[1] <= csr_wr_data;
            fk7_pkg::CsrOriginRow2: origin_ff[2] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance and stage valid bits
   logic           en;
   logic [Lat-1:0] vld_ff;

   assign rsp_valid = vld_ff[Lat-1];
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   // cordic state per stage and joint
   logic signed [Cw-1:0] cx_ff  [CORDIC_STEPS+1][Nj];
   logic signed [Cw-1:0] cy_ff  [CORDIC_STEPS+1][Nj];
   logic signed [Cw-1:0] cz_ff  [CORDIC_STEPS+1][Nj];
   logic                 neg_ff [CORDIC_STEPS+1][Nj];
   logic signed [15:0]   ang_w  [Nj];

   assign ang_w[0] = req_word.angle_0;
   assign ang_w[1] = req_word.angle_1;
   assign ang_w[2] = req_word.angle_2;
   assign ang_w[3] = req_word.angle_3;
   assign ang_w[4] = req_word.angle_4;
   assign ang_w[5] = req_word.angle_5;
   assign ang_w[6] = req_word.angle_6;

   // cosine and sine after rounding, carried along until their joint stage
   logic signed [15:0] cos_ff [Nj][Nj];
   logic signed [15:0] sin_ff [Nj][Nj];

   // running pose after each joint
   logic signed [15:0] pose_ff [Nj][3][4];

   for (genvar k = 0; k < Nj; k++) begin : g_lane
      logic signed [16:0] a1_w;
      logic signed [16:0] a2_w;
      logic               neg_w;

      // angle reduction into the cordic range
      always_comb begin
         a1_w = 17'(ang_w[k]);
         if (a1_w > fk7_pkg::PiQ12) a1_w = a1_w - fk7_pkg::TwoPiQ12;
         if (a1_w < -fk7_pkg::PiQ12) a1_w = a1_w + fk7_pkg::TwoPiQ12;
         neg_w = 1'b0;
         a2_w  = a1_w;
         if (a1_w > fk7_pkg::HalfPiQ12) begin
            a2_w  = a1_w - fk7_pkg::PiQ12;
            neg_w = 1'b1;
         end else if (a1_w < -fk7_pkg::HalfPiQ12) begin
            a2_w  = a1_w + fk7_pkg::PiQ12;
            neg_w = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[0][k]  <= fk7_pkg::GainQ24;
            cy_ff[0][k]  <= '0;
            cz_ff[0][k]  <= Cw'(a2_w) <<< 12;
            neg_ff[0][k] <= neg_w;
         end
      end

      // one cordic iteration per stage
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
         logic signed [Cw-1:0] dx_w;
         logic signed [Cw-1:0] dy_w;
         logic signed [Cw-1:0] at_w;

         assign dx_w = cy_ff[i][k] >>> i;
         assign dy_w = cx_ff[i][k] >>> i;
         assign at_w = fk7_pkg::atan_q24(i);

         always_ff @(posedge clock) begin
            if (en) begin
               if (!cz_ff[i][k][Cw-1]) begin
                  cx_ff[i+1][k] <= cx_ff[i][k] - dx_w;
                  cy_ff[i+1][k] <= cy_ff[i][k] + dy_w;
                  cz_ff[i+1][k] <= cz_ff[i][k] - at_w;
               end else begin
                  cx_ff[i+1][k] <= cx_ff[i][k] + dx_w;
                  cy_ff[i+1][k] <= cy_ff[i][k] - dy_w;
                  cz_ff[i+1][k] <= cz_ff[i][k] + at_w;
               end
               neg_ff[i+1][k] <= neg_ff[i][k];
            end
         end
      end

      // round to q4.12 and undo the half-turn fold
      logic signed [15:0] c_w;
      logic signed [15:0] s_w;
      assign c_w = fk7_pkg::round_unit(cx_ff[CORDIC_STEPS][k]);
      assign s_w = fk7_pkg::round_unit(cy_ff[CORDIC_STEPS][k]);

      always_ff @(posedge clock) begin
         if (en) begin
            cos_ff[0][k] <= neg_ff[CORDIC_STEPS][k] ? -c_w : c_w;
            sin_ff[0][k] <= neg_ff[CORDIC_STEPS][k] ? -s_w : s_w;
         end
      end

      for (genvar j = 0; j < k; j++) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               cos_ff[j+1][k] <= cos_ff[j][k];
               sin_ff[j+1][k] <= sin_ff[j][k];
            end
         end
      end
   end

   // one transform product per joint stage
   for (genvar j = 0; j < Nj; j++) begin : g_joint
      localparam int Ax = fk7_pkg::joint_axis(j);
      localparam int Au = (Ax + 1) % 3;
      localparam int Av = (Ax + 2) % 3;

      logic signed [15:0] p_w  [3][4];
      logic signed [15:0] rm_w [3][3];
      logic signed [15:0] t_w  [3];
      logic signed [15:0] n_w  [3][4];

      // pose coming into this joint
      for (genvar r = 0; r < 3; r++) begin : g_src
         for (genvar c = 0; c < 4; c++) begin : g_col
            if (j == 0) begin : g_base
               assign p_w[r][c] = origin_ff[r][16*c +: 16];
            end else begin : g_prev
               assign p_w[r][c] = pose_ff[j-1][r][c];
            end
         end
      end

      always_comb begin
         logic signed [fk7_pkg::AccW-1:0] acc;
         logic signed [31:0]              prod;
         for (int m = 0; m < 3; m++) begin
            for (int kk = 0; kk < 3; kk++) begin
               rm_w[m][kk] = '0;
            end
         end
         rm_w[Ax][Ax] = fk7_pkg::UnitQ12;
         rm_w[Au][Au] = cos_ff[j][j];
         rm_w[Av][Av] = cos_ff[j][j];
         rm_w[Av][Au] = sin_ff[j][j];
         rm_w[Au][Av] = -sin_ff[j][j];
         t_w[0] = fk7_pkg::link_x(j);
         t_w[1] = '0;
         t_w[2] = '0;
         if (j == 0) begin
            t_w[1] = side_ff ? -fk7_pkg::ShoulderY : fk7_pkg::ShoulderY;
         end
         for (int r = 0; r < 3; r++) begin
            for (int kk = 0; kk < 3; kk++) begin
               acc = '0;
               for (int m = 0; m < 3; m++) begin
                  prod = p_w[r][m] * rm_w[m][kk];
                  acc  = acc + fk7_pkg::AccW'(prod);
               end
               n_w[r][kk] = fk7_pkg::round_sat(acc);
            end
            acc = fk7_pkg::AccW'(p_w[r][3]) <<< 12;
            for (int m = 0; m < 3; m++) begin
               prod = p_w[r][m] * t_w[m];
               acc  = acc + fk7_pkg::AccW'(prod);
            end
            n_w[r][3] = fk7_pkg::round_sat(acc);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pose_ff[j] <= n_w;
         end
      end
   end

   // output word
   assign rsp_word.rot_00 = pose_ff[Nj-1][0][0];
   assign rsp_word.rot_01 = pose_ff[Nj-1][0][1];
   assign rsp_word.rot_02 = pose_ff[Nj-1][0][2];
   assign rsp_word.rot_10 = pose_ff[Nj-1][1][0];
   assign rsp_word.rot_11 = pose_ff[Nj-1][1][1];
   assign rsp_word.rot_12 = pose_ff[Nj-1][1][2];
   assign rsp_word.rot_20 = pose_ff[Nj-1][2][0];
   assign rsp_word.rot_21 = pose_ff[Nj-1][2][1];
   assign rsp_word.rot_22 = pose_ff[Nj-1][2][2];
   assign rsp_word.pos_x  = pose_ff[Nj-1][0][3];
   assign rsp_word.pos_y  = pose_ff[Nj-1][1][3];
   assign rsp_word.pos_z  = pose_ff[Nj-1][2][3];

   // checks
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0])
   `ASSERT_IMP(a_cos_range, clock, reset, vld_ff[Rnd],
      cos_ff[0][0] <= 16'sd4096 && cos_ff[0][0] >= -16'sd4096)
   `ASSERT_NEXT(a_freeze, clock, reset, rsp_valid && rsp_stall, $stable(vld_ff))

endmodule
